// ===== hdl/hfp_pkg.sv =====
// Package for the haptic finger PWM frame unit.
// Holds the shared widths, register codes, config struct and sequencer types.
// No dependencies; the design files refer to it by scoped names, the bench files import it.
package hfp_pkg;

  localparam int unsigned NUM_FINGERS  = 10;
  localparam int unsigned DIST_W       = 8;
  localparam int unsigned CNT_W        = 8;
  localparam int unsigned FRAME_W      = 16;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 8;
  localparam int unsigned FINGER_IDX_W = 4;

  // Register reset values
  localparam logic [CNT_W-1:0] FAR_THR_RST      = 8'd20;
  localparam logic [CNT_W-1:0] NEAR_THR_RST     = 8'd2;
  localparam logic [CNT_W-1:0] FAR_PERIOD_RST   = 8'd30;
  localparam logic [CNT_W-1:0] NEAR_DUTY_RST    = 8'd40;
  localparam logic [CNT_W-1:0] NEAR_PERIOD_RST  = 8'd60;
  localparam logic [CNT_W-1:0] TOUCH_DUTY_RST   = 8'd16;
  localparam logic [CNT_W-1:0] TOUCH_PERIOD_RST = 8'd60;

  // Wrist PWM settings out of reset
  localparam logic [CNT_W-1:0] WRIST_DUTY_RST   = 8'd0;
  localparam logic [CNT_W-1:0] WRIST_PERIOD_RST = 8'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAR_THR,
    CFG_NEAR_THR,
    CFG_FAR_PERIOD,
    CFG_NEAR_DUTY,
    CFG_NEAR_PERIOD,
    CFG_TOUCH_DUTY,
    CFG_TOUCH_PERIOD
  } cfg_reg_e;

  typedef struct packed {
    logic [CNT_W-1:0] far_thr;
    logic [CNT_W-1:0] near_thr;
    logic [CNT_W-1:0] far_period;
    logic [CNT_W-1:0] near_duty;
    logic [CNT_W-1:0] near_period;
    logic [CNT_W-1:0] touch_duty;
    logic [CNT_W-1:0] touch_period;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH,
    ST_EMIT
  } seq_state_e;

  // Counter memory port controls
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctrl_t;

endpackage

// ===== hdl/hfp_if.sv =====
// Valid/ready channel interfaces for the haptic finger PWM frame unit.
// Depends on hfp_pkg for the field widths.
interface hfp_dist_if;
  logic                                valid;
  logic                                ready;
  logic signed [hfp_pkg::DIST_W-1:0]   dist_finger_0;
  logic signed [hfp_pkg::DIST_W-1:0]   dist_finger_1;
  logic signed [hfp_pkg::DIST_W-1:0]   dist_finger_2;
  logic signed [hfp_pkg::DIST_W-1:0]   dist_finger_3;
  logic signed [hfp_pkg::DIST_W-1:0]   dist_finger_4;
  logic signed [hfp_pkg::DIST_W-1:0]   dist_finger_5;
  logic signed [hfp_pkg::DIST_W-1:0]   dist_finger_6;
  logic signed [hfp_pkg::DIST_W-1:0]   dist_finger_7;
  logic signed [hfp_pkg::DIST_W-1:0]   dist_finger_8;
  logic signed [hfp_pkg::DIST_W-1:0]   dist_finger_9;

  modport source (
    output valid, dist_finger_0, dist_finger_1, dist_finger_2, dist_finger_3,
           dist_finger_4, dist_finger_5, dist_finger_6, dist_finger_7,
           dist_finger_8, dist_finger_9,
    input  ready
  );
  modport sink (
    input  valid, dist_finger_0, dist_finger_1, dist_finger_2, dist_finger_3,
           dist_finger_4, dist_finger_5, dist_finger_6, dist_finger_7,
           dist_finger_8, dist_finger_9,
    output ready
  );
endinterface

interface hfp_frame_if;
  logic                          valid;
  logic                          ready;
  logic [hfp_pkg::FRAME_W-1:0]   left_hand_bits;
  logic [hfp_pkg::FRAME_W-1:0]   right_hand_bits;

  modport source (output valid, left_hand_bits, right_hand_bits, input ready);
  modport sink   (input  valid, left_hand_bits, right_hand_bits, output ready);
endinterface

// ===== hdl/hfp_count_mem.sv =====
// PWM sub-cycle counter memory: one write and one registered read per cycle.
// Per-entry valid bits make never-written entries read as zero after reset.
// Depends on hfp_pkg.
module hfp_count_mem #(
  parameter int unsigned DEPTH = 12,
  parameter int unsigned AW    = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hfp_pkg::mem_ctrl_t          ctrl_i,
  input  logic [AW-1:0]               raddr_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [hfp_pkg::CNT_W-1:0]   wdata_i,
  output logic [hfp_pkg::CNT_W-1:0]   rdata_o
);

  logic [hfp_pkg::CNT_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]          vld_q;
  logic [hfp_pkg::CNT_W-1:0] rdata_q;
  logic                      rvld_q;

  // Storage array: write port and registered read port
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem[raddr_i];
    end
  end

  // Track written entries; registered valid follows the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (ctrl_i.wr_en) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (ctrl_i.rd_en) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

// ===== hdl/hfp_engine.sv =====
// Frame sequencer: walks the finger and wrist slots of both hands, does the
// counter read-modify-write against hfp_count_mem, builds frames, holds output.
// Depends on hfp_pkg and the channel interfaces in hfp_if.
module hfp_engine #(
  parameter int unsigned FINGERS_PER_HAND = 5,
  parameter int unsigned FRAME_BITS       = 16,
  parameter int unsigned AW               = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hfp_pkg::cfg_t               cfg_i,
  hfp_dist_if.sink                    dist_i,
  hfp_frame_if.source                 frame_o,
  output hfp_pkg::mem_ctrl_t          mem_ctrl_o,
  output logic [AW-1:0]               mem_raddr_o,
  output logic [AW-1:0]               mem_waddr_o,
  output logic [hfp_pkg::CNT_W-1:0]   mem_wdata_o,
  input  logic [hfp_pkg::CNT_W-1:0]   mem_rdata_i
);

  localparam int unsigned F     = FINGERS_PER_HAND;
  localparam int unsigned PosW  = $clog2(F + 1);
  localparam int unsigned PadLo = 2 * F + 2;
  localparam logic [hfp_pkg::FRAME_W-1:0] PadMask =
      (16'hFFFF << PadLo) & ~(16'hFFFF << FRAME_BITS);
  localparam logic [PosW-1:0] WristPos = PosW'(F);

  hfp_pkg::seq_state_e state_q, state_d;

  logic [hfp_pkg::DIST_W-1:0]  dist_q [hfp_pkg::NUM_FINGERS];
  logic                        rd_hand_q;
  logic [PosW-1:0]             rd_pos_q;
  logic                        b_vld_q;
  logic                        b_hand_q;
  logic [PosW-1:0]             b_pos_q;
  logic [AW-1:0]               b_addr_q;
  logic [hfp_pkg::FRAME_W-1:0] frame_q [2];
  logic [hfp_pkg::CNT_W-1:0]   wrist_duty_q [2];
  logic [hfp_pkg::CNT_W-1:0]   wrist_period_q [2];
  logic                        wrist_lon_q [2];
  logic                        wrist_ron_q [2];
  logic                        out_vld_q;
  logic [hfp_pkg::FRAME_W-1:0] out_left_q;
  logic [hfp_pkg::FRAME_W-1:0] out_right_q;

  logic                        in_xfer;
  logic                        issue;
  logic                        load_out;
  logic [AW-1:0]               rd_addr;

  logic                        neg [hfp_pkg::NUM_FINGERS];
  logic                        far [hfp_pkg::NUM_FINGERS];
  logic [hfp_pkg::CNT_W-1:0]   mag [hfp_pkg::NUM_FINGERS];
  logic                        all_far [2];

  logic [hfp_pkg::FINGER_IDX_W-1:0] cur_idx;
  logic [hfp_pkg::FINGER_IDX_W-1:0] thumb_idx;
  logic                        cur_near;
  logic                        trig;
  logic [hfp_pkg::CNT_W-1:0]   duty;
  logic [hfp_pkg::CNT_W-1:0]   period;
  logic                        lon;
  logic                        ron;
  logic                        pwm_on;
  logic [hfp_pkg::CNT_W-1:0]   cnt_inc;
  logic [hfp_pkg::CNT_W-1:0]   cnt_next;

  // Sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hfp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state, read issue and output load
  always_comb begin
    state_d  = state_q;
    issue    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      hfp_pkg::ST_IDLE: begin
        if (dist_i.valid) begin
          state_d = hfp_pkg::ST_RUN;
        end
      end
      hfp_pkg::ST_RUN: begin
        issue = 1'b1;
        if (rd_hand_q && (rd_pos_q == WristPos)) begin
          state_d = hfp_pkg::ST_FLUSH;
        end
      end
      hfp_pkg::ST_FLUSH: begin
        state_d = hfp_pkg::ST_EMIT;
      end
      hfp_pkg::ST_EMIT: begin
        if (!out_vld_q || frame_o.ready) begin
          load_out = 1'b1;
          state_d  = hfp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = hfp_pkg::ST_IDLE;
      end
    endcase
  end

  assign dist_i.ready = (state_q == hfp_pkg::ST_IDLE);
  assign in_xfer      = dist_i.valid && dist_i.ready;

  // Slot address: fingers first, then the two wrists
  assign rd_addr = (rd_pos_q == WristPos)
                   ? AW'(2 * F + 32'(rd_hand_q))
                   : AW'(32'(rd_hand_q) * F + 32'(rd_pos_q));

  // Advance the slot walk; stage the slot for the modify/write cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_hand_q <= 1'b0;
      rd_pos_q  <= '0;
      b_vld_q   <= 1'b0;
    end else begin
      b_vld_q <= issue;
      if (in_xfer) begin
        rd_hand_q <= 1'b0;
        rd_pos_q  <= '0;
      end else if (issue) begin
        if (rd_pos_q == WristPos) begin
          rd_pos_q  <= '0;
          rd_hand_q <= 1'b1;
        end else begin
          rd_pos_q <= rd_pos_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      b_hand_q <= rd_hand_q;
      b_pos_q  <= rd_pos_q;
      b_addr_q <= rd_addr;
    end
  end

  // Capture the distances of the accepted tick
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      dist_q[0] <= dist_i.dist_finger_0;
      dist_q[1] <= dist_i.dist_finger_1;
      dist_q[2] <= dist_i.dist_finger_2;
      dist_q[3] <= dist_i.dist_finger_3;
      dist_q[4] <= dist_i.dist_finger_4;
      dist_q[5] <= dist_i.dist_finger_5;
      dist_q[6] <= dist_i.dist_finger_6;
      dist_q[7] <= dist_i.dist_finger_7;
      dist_q[8] <= dist_i.dist_finger_8;
      dist_q[9] <= dist_i.dist_finger_9;
    end
  end

  // Per-finger sign, magnitude and far test; a hand is all-far if every finger is
  always_comb begin
    for (int i = 0; i < hfp_pkg::NUM_FINGERS; i++) begin
      neg[i] = dist_q[i][hfp_pkg::DIST_W-1];
      mag[i] = neg[i] ? (~dist_q[i] + 1'b1) : dist_q[i];
      far[i] = (mag[i] >= cfg_i.far_thr);
    end
    for (int h = 0; h < 2; h++) begin
      all_far[h] = 1'b1;
      for (int f = 0; f < F; f++) begin
        all_far[h] = all_far[h] & far[h * F + f];
      end
    end
  end

  assign cur_idx   = hfp_pkg::FINGER_IDX_W'(32'(b_hand_q) * F + 32'(b_pos_q));
  assign thumb_idx = b_hand_q ? hfp_pkg::FINGER_IDX_W'(F)
                              : hfp_pkg::FINGER_IDX_W'(F - 1);
  assign cur_near  = (mag[cur_idx] >= cfg_i.near_thr);
  assign trig      = all_far[b_hand_q];

  // Pick duty, period and active sides for the slot in the write stage
  always_comb begin
    if (b_pos_q == WristPos) begin
      if (trig) begin
        duty   = cfg_i.near_duty;
        period = cfg_i.near_period;
        lon    = !neg[thumb_idx];
        ron    = neg[thumb_idx];
      end else begin
        duty   = wrist_duty_q[b_hand_q];
        period = wrist_period_q[b_hand_q];
        lon    = wrist_lon_q[b_hand_q];
        ron    = wrist_ron_q[b_hand_q];
      end
    end else if (far[cur_idx]) begin
      duty   = '0;
      period = cfg_i.far_period;
      lon    = !neg[cur_idx];
      ron    = neg[cur_idx];
    end else if (cur_near) begin
      duty   = cfg_i.near_duty;
      period = cfg_i.near_period;
      lon    = !neg[cur_idx];
      ron    = neg[cur_idx];
    end else begin
      duty   = cfg_i.touch_duty;
      period = cfg_i.touch_period;
      lon    = 1'b1;
      ron    = 1'b1;
    end
  end

  // Counter step: on below duty, then advance and wrap past the period
  assign pwm_on   = (mem_rdata_i < duty);
  assign cnt_inc  = mem_rdata_i + 1'b1;
  assign cnt_next = (cnt_inc > period) ? '0 : cnt_inc;

  assign mem_ctrl_o.rd_en = issue;
  assign mem_ctrl_o.wr_en = b_vld_q;
  assign mem_raddr_o      = rd_addr;
  assign mem_waddr_o      = b_addr_q;
  assign mem_wdata_o      = cnt_next;

  // Latch triggered wrist settings; they stay until the next trigger of that hand or reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int h = 0; h < 2; h++) begin
        wrist_duty_q[h]   <= hfp_pkg::WRIST_DUTY_RST;
        wrist_period_q[h] <= hfp_pkg::WRIST_PERIOD_RST;
        wrist_lon_q[h]    <= 1'b1;
        wrist_ron_q[h]    <= 1'b1;
      end
    end else if (b_vld_q && (b_pos_q == WristPos) && trig) begin
      wrist_duty_q[b_hand_q]   <= duty;
      wrist_period_q[b_hand_q] <= period;
      wrist_lon_q[b_hand_q]    <= lon;
      wrist_ron_q[b_hand_q]    <= ron;
    end
  end

  // Build frames: preset padding on transfer, fill one bit pair per slot
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      frame_q[0] <= PadMask;
      frame_q[1] <= PadMask;
    end else if (b_vld_q) begin
      for (int k = 0; k <= F; k++) begin
        if (b_pos_q == PosW'(k)) begin
          frame_q[b_hand_q][2 * k]     <= pwm_on & lon;
          frame_q[b_hand_q][2 * k + 1] <= pwm_on & ron;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load_out) begin
      out_vld_q <= 1'b1;
    end else if (frame_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_left_q  <= frame_q[0];
      out_right_q <= frame_q[1];
    end
  end

  assign frame_o.valid           = out_vld_q;
  assign frame_o.left_hand_bits  = out_left_q;
  assign frame_o.right_hand_bits = out_right_q;

endmodule

// ===== hdl/haptic_finger_pwm_frame_unit.sv =====
// Each accepted tick does one read-modify-write per finger and wrist counter through the
// single counter memory port pair, then loads its frames; a new tick is taken only after that.
// The load waits while the output register holds a frame pair that has not been taken.
// A finished frame pair waits in the output register while the next tick is taken.
// Reset (async, active low): registers to defaults, wrist settings to defaults,
// counters read as zero through per-entry valid bits; no clearing pass.
module haptic_finger_pwm_frame_unit #(
  parameter int unsigned FINGERS_PER_HAND = 5,
  parameter int unsigned FRAME_BITS       = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [hfp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [hfp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  hfp_dist_if.sink                         dist_i,
  hfp_frame_if.source                      frame_o
);

  localparam int unsigned NumEntries = 2 * FINGERS_PER_HAND + 2;
  localparam int unsigned AddrW      = $clog2(NumEntries);

  hfp_pkg::cfg_t              cfg_q;
  hfp_pkg::mem_ctrl_t         mem_ctrl;
  logic [AddrW-1:0]           mem_raddr;
  logic [AddrW-1:0]           mem_waddr;
  logic [hfp_pkg::CNT_W-1:0]  mem_wdata;
  logic [hfp_pkg::CNT_W-1:0]  mem_rdata;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.far_thr      <= hfp_pkg::FAR_THR_RST;
      cfg_q.near_thr     <= hfp_pkg::NEAR_THR_RST;
      cfg_q.far_period   <= hfp_pkg::FAR_PERIOD_RST;
      cfg_q.near_duty    <= hfp_pkg::NEAR_DUTY_RST;
      cfg_q.near_period  <= hfp_pkg::NEAR_PERIOD_RST;
      cfg_q.touch_duty   <= hfp_pkg::TOUCH_DUTY_RST;
      cfg_q.touch_period <= hfp_pkg::TOUCH_PERIOD_RST;
    end else if (cfg_we_i) begin
      case (hfp_pkg::cfg_reg_e'(cfg_idx_i))
        hfp_pkg::CFG_FAR_THR:      cfg_q.far_thr      <= cfg_data_i;
        hfp_pkg::CFG_NEAR_THR:     cfg_q.near_thr     <= cfg_data_i;
        hfp_pkg::CFG_FAR_PERIOD:   cfg_q.far_period   <= cfg_data_i;
        hfp_pkg::CFG_NEAR_DUTY:    cfg_q.near_duty    <= cfg_data_i;
        hfp_pkg::CFG_NEAR_PERIOD:  cfg_q.near_period  <= cfg_data_i;
        hfp_pkg::CFG_TOUCH_DUTY:   cfg_q.touch_duty   <= cfg_data_i;
        hfp_pkg::CFG_TOUCH_PERIOD: cfg_q.touch_period <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  hfp_count_mem #(
    .DEPTH (NumEntries),
    .AW    (AddrW)
  ) u_count_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mem_ctrl),
    .raddr_i (mem_raddr),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  hfp_engine #(
    .FINGERS_PER_HAND (FINGERS_PER_HAND),
    .FRAME_BITS       (FRAME_BITS),
    .AW               (AddrW)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .dist_i      (dist_i),
    .frame_o     (frame_o),
    .mem_ctrl_o  (mem_ctrl),
    .mem_raddr_o (mem_raddr),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

endmodule

// ===== hdl/hfp_checker.sv =====
// Port-level checker for the haptic finger PWM frame unit, bound to the top level.
// Depends on hfp_pkg and on the top level's channel interface ports.
module hfp_checker #(
  parameter int unsigned FINGERS_PER_HAND = 5,
  parameter int unsigned FRAME_BITS       = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [hfp_pkg::FRAME_W-1:0]   left_bits_i,
  input logic [hfp_pkg::FRAME_W-1:0]   right_bits_i
);

  localparam int unsigned Lat   = 2 * FINGERS_PER_HAND + 5;
  localparam int unsigned PadLo = 2 * FINGERS_PER_HAND + 2;
  localparam logic [hfp_pkg::FRAME_W-1:0] PadMask =
      (16'hFFFF << PadLo) & ~(16'hFFFF << FRAME_BITS);
  localparam logic [hfp_pkg::FRAME_W-1:0] UsedMask = ~(16'hFFFF << FRAME_BITS);

  // A stalled result holds its frames
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(left_bits_i)
                                    && $stable(right_bits_i))
    else $error("stalled frame transfer changed");

  // One tick at a time: no transfer right after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while a tick is in work");

  // With the output free at the transfer, frames show up once the slot walk has finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !out_valid_i |-> ##Lat out_valid_i)
    else $error("frames missing after the slot walk");

  // Padding bits are ones and bits past the frame are zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((left_bits_i & PadMask) == PadMask)
                    && ((right_bits_i & PadMask) == PadMask)
                    && ((left_bits_i & ~UsedMask) == '0)
                    && ((right_bits_i & ~UsedMask) == '0))
    else $error("frame padding wrong");

endmodule

bind haptic_finger_pwm_frame_unit hfp_checker #(
  .FINGERS_PER_HAND (FINGERS_PER_HAND),
  .FRAME_BITS       (FRAME_BITS)
) u_hfp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (dist_i.valid),
  .in_ready_i   (dist_i.ready),
  .out_valid_i  (frame_o.valid),
  .out_ready_i  (frame_o.ready),
  .left_bits_i  (frame_o.left_hand_bits),
  .right_bits_i (frame_o.right_hand_bits)
);

// ===== bench/hfp_frame_checker.sv =====
// Scoreboard for the haptic finger PWM frame unit: watches both channels and config writes.
// Predicts each frame pair from its own copy of the PWM state and compares field by field.
// Depends on hfp_pkg and the channel interfaces in hfp_if.sv.
`timescale 1ns / 100ps
module hfp_frame_checker #(
  parameter int unsigned FINGERS_PER_HAND = 5,
  parameter int unsigned FRAME_BITS       = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [hfp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hfp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  hfp_dist_if                            dist_i,
  hfp_frame_if                           frame_i,
  output int                             mismatch_cnt_o,
  output int                             frames_pending_o
);
  import hfp_pkg::*;

  typedef logic [NUM_FINGERS-1:0][DIST_W-1:0] tick_t;
  typedef struct packed {
    logic [FRAME_W-1:0] left_bits;
    logic [FRAME_W-1:0] right_bits;
  } frame_pair_t;

  // Shadow of the block's registers and PWM counters
  cfg_t             regs;
  logic [CNT_W-1:0] finger_cnt   [NUM_FINGERS];
  logic [CNT_W-1:0] wrist_cnt    [2];
  logic [CNT_W-1:0] wrist_duty   [2];
  logic [CNT_W-1:0] wrist_period [2];
  logic             wrist_lside  [2];
  logic             wrist_rside  [2];

  frame_pair_t frames_due [$];
  int          errors;

  // Advance a counter and wrap to zero once it passes the period
  function automatic logic [CNT_W-1:0] next_count(logic [CNT_W-1:0] cnt,
                                                  logic [CNT_W-1:0] period);
    logic [CNT_W-1:0] nxt;
    nxt = cnt + 1'b1;
    return (nxt > period) ? '0 : nxt;
  endfunction

  // Build both hand frames for one tick and step every counter once
  function automatic frame_pair_t build_frames(tick_t d);
    frame_pair_t      res;
    logic [FRAME_W-1:0] frame;
    logic [CNT_W-1:0] duty   [FINGERS_PER_HAND];
    logic [CNT_W-1:0] period [FINGERS_PER_HAND];
    logic             lside  [FINGERS_PER_HAND];
    logic             rside  [FINGERS_PER_HAND];
    int               far_cnt, idx, raw, mag, thumb, bitpos;
    logic             on;
    for (int h = 0; h < 2; h++) begin
      far_cnt = 0;
      frame   = '0;
      bitpos  = 0;
      // Classify each finger by sign and magnitude band
      for (int f = 0; f < FINGERS_PER_HAND; f++) begin
        idx = h * FINGERS_PER_HAND + f;
        raw = int'(d[idx]);
        if (raw >= 128) begin
          mag = 256 - raw;
          lside[f] = 1'b0;
          rside[f] = 1'b1;
        end else begin
          mag = raw;
          lside[f] = 1'b1;
          rside[f] = 1'b0;
        end
        if (mag >= int'(regs.far_thr)) begin
          duty[f]   = '0;
          period[f] = regs.far_period;
          far_cnt++;
        end else if (mag >= int'(regs.near_thr)) begin
          duty[f]   = regs.near_duty;
          period[f] = regs.near_period;
        end else begin
          duty[f]   = regs.touch_duty;
          period[f] = regs.touch_period;
          lside[f]  = 1'b1;
          rside[f]  = 1'b1;
        end
      end
      // Latch wrist settings when the whole hand is far
      thumb = (h == 0) ? FINGERS_PER_HAND - 1 : 0;
      if (far_cnt == FINGERS_PER_HAND) begin
        wrist_duty[h]   = regs.near_duty;
        wrist_period[h] = regs.near_period;
        wrist_lside[h]  = lside[thumb];
        wrist_rside[h]  = rside[thumb];
      end
      for (int f = 0; f < FINGERS_PER_HAND; f++) begin
        idx = h * FINGERS_PER_HAND + f;
        on  = finger_cnt[idx] < duty[f];
        finger_cnt[idx] = next_count(finger_cnt[idx], period[f]);
        frame[bitpos]   = on & lside[f];
        frame[bitpos+1] = on & rside[f];
        bitpos += 2;
      end
      on = wrist_cnt[h] < wrist_duty[h];
      wrist_cnt[h] = next_count(wrist_cnt[h], wrist_period[h]);
      frame[bitpos]   = on & wrist_lside[h];
      frame[bitpos+1] = on & wrist_rside[h];
      bitpos += 2;
      // Pad the rest of the frame with ones
      while (bitpos < FRAME_BITS && bitpos < FRAME_W) begin
        frame[bitpos] = 1'b1;
        bitpos++;
      end
      if (h == 0) res.left_bits = frame;
      else res.right_bits = frame;
    end
    return res;
  endfunction

  function automatic void report(string field, logic [FRAME_W-1:0] exp_bits,
                                 logic [FRAME_W-1:0] got_bits);
    if (errors < 10)
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, field, exp_bits, got_bits);
    errors++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_pair_t due;
    tick_t       seen;
    if (!rst_ni) begin
      regs.far_thr      = FAR_THR_RST;
      regs.near_thr     = NEAR_THR_RST;
      regs.far_period   = FAR_PERIOD_RST;
      regs.near_duty    = NEAR_DUTY_RST;
      regs.near_period  = NEAR_PERIOD_RST;
      regs.touch_duty   = TOUCH_DUTY_RST;
      regs.touch_period = TOUCH_PERIOD_RST;
      for (int i = 0; i < NUM_FINGERS; i++) finger_cnt[i] = '0;
      for (int h = 0; h < 2; h++) begin
        wrist_cnt[h]    = '0;
        wrist_duty[h]   = WRIST_DUTY_RST;
        wrist_period[h] = WRIST_PERIOD_RST;
        wrist_lside[h]  = 1'b1;
        wrist_rside[h]  = 1'b1;
      end
      frames_due.delete();
      errors = 0;
      mismatch_cnt_o   <= 0;
      frames_pending_o <= 0;
    end else begin
      // Track register writes
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_FAR_THR:      regs.far_thr      = cfg_data_i;
          CFG_NEAR_THR:     regs.near_thr     = cfg_data_i;
          CFG_FAR_PERIOD:   regs.far_period   = cfg_data_i;
          CFG_NEAR_DUTY:    regs.near_duty    = cfg_data_i;
          CFG_NEAR_PERIOD:  regs.near_period  = cfg_data_i;
          CFG_TOUCH_DUTY:   regs.touch_duty   = cfg_data_i;
          CFG_TOUCH_PERIOD: regs.touch_period = cfg_data_i;
          default: ;
        endcase
      end
      // Predict on every input transfer
      if (dist_i.valid && dist_i.ready) begin
        seen = {dist_i.dist_finger_9, dist_i.dist_finger_8, dist_i.dist_finger_7,
                dist_i.dist_finger_6, dist_i.dist_finger_5, dist_i.dist_finger_4,
                dist_i.dist_finger_3, dist_i.dist_finger_2, dist_i.dist_finger_1,
                dist_i.dist_finger_0};
        frames_due.push_back(build_frames(seen));
      end
      // Compare every output transfer with the oldest prediction
      if (frame_i.valid && frame_i.ready) begin
        if (frames_due.size() == 0) begin
          if (errors < 10)
            $display("%0t: frame transfer with nothing predicted: left %h right %h",
                     $realtime, frame_i.left_hand_bits, frame_i.right_hand_bits);
          errors++;
        end else begin
          due = frames_due.pop_front();
          if (frame_i.left_hand_bits !== due.left_bits)
            report("left_hand_bits", due.left_bits, frame_i.left_hand_bits);
          if (frame_i.right_hand_bits !== due.right_bits)
            report("right_hand_bits", due.right_bits, frame_i.right_hand_bits);
        end
      end
      mismatch_cnt_o   <= errors;
      frames_pending_o <= frames_due.size();
    end
  end

endmodule

// ===== bench/tb.sv =====
// Top of the frame unit bench: clock, reset, config phases, tick stimulus and back-pressure.
// Depends on hfp_pkg, hfp_if.sv, the unit itself and hfp_frame_checker.
`timescale 1ns / 100ps
module tb;
  import hfp_pkg::*;

  localparam int unsigned FINGERS_PER_HAND = 5;
  localparam int unsigned FRAME_BITS       = 16;
  localparam int          SETTLE_CYCLES    = 2 * FINGERS_PER_HAND + 15;
  localparam int          STALL_LIMIT      = 5000;
  localparam int          PHASE_TICKS      = 150;

  typedef logic [NUM_FINGERS-1:0][DIST_W-1:0] tick_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  int                    mismatch_cnt;
  int                    frames_pending;
  logic                  steady;
  cfg_t                  active_cfg;

  hfp_dist_if  dist_if ();
  hfp_frame_if frame_if ();

  haptic_finger_pwm_frame_unit #(
    .FINGERS_PER_HAND(FINGERS_PER_HAND),
    .FRAME_BITS      (FRAME_BITS)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .dist_i    (dist_if),
    .frame_o   (frame_if)
  );

  hfp_frame_checker #(
    .FINGERS_PER_HAND(FINGERS_PER_HAND),
    .FRAME_BITS      (FRAME_BITS)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .dist_i          (dist_if),
    .frame_i         (frame_if),
    .mismatch_cnt_o  (mismatch_cnt),
    .frames_pending_o(frames_pending)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Random back-pressure on the frame channel, always ready while steady is set
  initial begin : frame_sink
    frame_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      frame_if.ready <= steady || ($urandom_range(99) >= 22);
    end
  end

  // End the run when nothing transfers for too long
  initial begin : watchdog
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((dist_if.valid && dist_if.ready) || (frame_if.valid && frame_if.ready) || cfg_we_i)
        stall = 0;
      else
        stall++;
    end
    $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // Turn a magnitude and side into a distance code; 128 only exists as -128
  function automatic logic [DIST_W-1:0] to_dist(int mag, bit neg);
    if (mag < 0) mag = 0;
    if (mag > 128) mag = 128;
    if (neg || mag == 128) return DIST_W'(-mag);
    return DIST_W'(mag);
  endfunction

  // Pick one distance: 0 any code, 1 far, 2 near, 3 on key, 4 within one of a threshold
  function automatic logic [DIST_W-1:0] pick_dist(int band);
    int  far_t, near_t, t;
    bit  neg;
    far_t  = int'(active_cfg.far_thr);
    near_t = int'(active_cfg.near_thr);
    neg    = 1'($urandom_range(1));
    case (band)
      1: return to_dist($urandom_range(128, far_t), neg);
      2: begin
        if (far_t - 1 < near_t) return to_dist($urandom_range(128), neg);
        return to_dist($urandom_range(far_t - 1, near_t), neg);
      end
      3: return to_dist((near_t > 0) ? $urandom_range(near_t - 1) : 0, neg);
      4: begin
        t = $urandom_range(1) ? far_t : near_t;
        return to_dist(t + $urandom_range(2) - 1, neg);
      end
      default: return DIST_W'($urandom_range(255));
    endcase
  endfunction

  // Mostly ticks with one hand far, banded fingers or all fingers far, the rest raw noise
  function automatic tick_t make_tick();
    tick_t t;
    int    shape, far_hand;
    shape    = $urandom_range(99);
    far_hand = $urandom_range(1);
    for (int i = 0; i < NUM_FINGERS; i++) begin
      if (shape < 25)
        t[i] = pick_dist(0);
      else if (shape < 55)
        t[i] = (i / FINGERS_PER_HAND == far_hand) ? pick_dist(1)
                                                   : pick_dist($urandom_range(4));
      else if (shape < 85)
        t[i] = pick_dist($urandom_range(4));
      else
        t[i] = pick_dist(1);
    end
    return t;
  endfunction

  // Hold valid until the tick transfers; idle for a random gap first, none while steady
  task automatic send_tick(tick_t t);
    int gap;
    gap = 0;
    while (!steady && $urandom_range(99) < 22) gap++;
    if (gap > 0) begin
      dist_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    dist_if.valid         <= 1'b1;
    dist_if.dist_finger_0 <= t[0];
    dist_if.dist_finger_1 <= t[1];
    dist_if.dist_finger_2 <= t[2];
    dist_if.dist_finger_3 <= t[3];
    dist_if.dist_finger_4 <= t[4];
    dist_if.dist_finger_5 <= t[5];
    dist_if.dist_finger_6 <= t[6];
    dist_if.dist_finger_7 <= t[7];
    dist_if.dist_finger_8 <= t[8];
    dist_if.dist_finger_9 <= t[9];
    @(posedge clk_i);
    while (!dist_if.ready) @(posedge clk_i);
  endtask

  // Drop valid, wait for every predicted frame, then let the pipeline settle
  task automatic drain();
    dist_if.valid <= 1'b0;
    do @(posedge clk_i); while (frames_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  // Write all seven registers back to back with the enable held high
  task automatic apply_settings(cfg_t c);
    cfg_we_i <= 1'b1;
    write_reg(CFG_FAR_THR, c.far_thr);
    write_reg(CFG_NEAR_THR, c.near_thr);
    write_reg(CFG_FAR_PERIOD, c.far_period);
    write_reg(CFG_NEAR_DUTY, c.near_duty);
    write_reg(CFG_NEAR_PERIOD, c.near_period);
    write_reg(CFG_TOUCH_DUTY, c.touch_duty);
    write_reg(CFG_TOUCH_PERIOD, c.touch_period);
    cfg_we_i <= 1'b0;
    active_cfg = c;
  endtask

  function automatic cfg_t phase_setting(int p);
    cfg_t c;
    case (p)
      1: c = '{far_thr: 8'd128, near_thr: 8'd0, far_period: 8'd0, near_duty: 8'd255,
               near_period: 8'd254, touch_duty: 8'd0, touch_period: 8'd254};
      2: c = '{far_thr: 8'd0, near_thr: 8'd128, far_period: 8'd254, near_duty: 8'd0,
               near_period: 8'd0, touch_duty: 8'd255, touch_period: 8'd0};
      3: c = '{far_thr: 8'd10, near_thr: 8'd30, far_period: 8'd5, near_duty: 8'd3,
               near_period: 8'd7, touch_duty: 8'd2, touch_period: 8'd4};
      5: c = '{far_thr: 8'd1, near_thr: 8'd1, far_period: 8'd3, near_duty: 8'd2,
               near_period: 8'd3, touch_duty: 8'd255, touch_period: 8'd254};
      default: begin
        c.far_thr      = 8'($urandom_range(128));
        c.near_thr     = 8'($urandom_range(128));
        c.far_period   = 8'($urandom_range(24));
        c.near_duty    = 8'($urandom_range(30));
        c.near_period  = 8'($urandom_range(24));
        c.touch_duty   = 8'($urandom_range(30));
        c.touch_period = 8'($urandom_range(24));
      end
    endcase
    return c;
  endfunction

  initial begin : stimulus
    tick_t dir_q [$];
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = '0;
    cfg_data_i            = '0;
    steady                = 1'b0;
    dist_if.valid         = 1'b0;
    dist_if.dist_finger_0 = '0;
    dist_if.dist_finger_1 = '0;
    dist_if.dist_finger_2 = '0;
    dist_if.dist_finger_3 = '0;
    dist_if.dist_finger_4 = '0;
    dist_if.dist_finger_5 = '0;
    dist_if.dist_finger_6 = '0;
    dist_if.dist_finger_7 = '0;
    dist_if.dist_finger_8 = '0;
    dist_if.dist_finger_9 = '0;
    active_cfg = '{far_thr: FAR_THR_RST, near_thr: NEAR_THR_RST,
                   far_period: FAR_PERIOD_RST, near_duty: NEAR_DUTY_RST,
                   near_period: NEAR_PERIOD_RST, touch_duty: TOUCH_DUTY_RST,
                   touch_period: TOUCH_PERIOD_RST};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed ticks under the reset settings: bands, band edges, signs, wrist triggers
    dir_q.push_back({10{8'h00}});                       // on key, both sides
    dir_q.push_back({10{8'h7F}});                       // all far, pushing left
    dir_q.push_back({10{8'h80}});                       // -128 counts as magnitude 128
    dir_q.push_back({10{8'h13}});                       // just under far
    dir_q.push_back({10{8'h14}});                       // exactly far
    dir_q.push_back({10{8'hEC}});                       // -20, far on the right
    dir_q.push_back({10{8'h02}});                       // exactly near
    dir_q.push_back({10{8'hFE}});                       // -2, near on the right
    dir_q.push_back({10{8'h01}});                       // just under near
    dir_q.push_back({10{8'hFF}});                       // -1 is on key
    dir_q.push_back({{5{8'h00}}, {5{8'h7F}}});          // left hand far only
    dir_q.push_back({{4{8'h40}}, 8'hC0, {5{8'h00}}});   // right far, thumb pushes right
    dir_q.push_back({{5{8'h03}}, 8'h90, {4{8'h30}}});   // left far, thumb pushes right
    dir_q.push_back({5{8'h55, 8'hAA}});
    dir_q.push_back({5{8'hAA, 8'h55}});
    foreach (dir_q[i]) send_tick(dir_q[i]);
    repeat (PHASE_TICKS - dir_q.size()) send_tick(make_tick());

    // Setting phases, each applied once the unit is idle
    for (int p = 1; p <= 6; p++) begin
      drain();
      apply_settings(phase_setting(p));
      steady = (p == 4);
      for (int n = 0; n < PHASE_TICKS; n++) begin
        // Hold the sender until everything predicted has come out
        if (p == 2 && n == PHASE_TICKS / 2) drain();
        send_tick(make_tick());
      end
      steady = 1'b0;
    end
    drain();

    if (mismatch_cnt == 0 && frames_pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/hfp_pkg.sv
hdl/hfp_if.sv
hdl/hfp_count_mem.sv
hdl/hfp_engine.sv
hdl/haptic_finger_pwm_frame_unit.sv
hdl/hfp_checker.sv
bench/hfp_frame_checker.sv
bench/tb.sv
